@@ hdl/sgng_pkg.sv @@
// shared types and constants for the sequence gap nack generator
`default_nettype none

package sgng_pkg;

    localparam int NUM_TYPES   = 16;
    localparam int TYPE_W      = $clog2(NUM_TYPES);
    localparam int MAX_MISSING = 10;
    localparam int MISS_W      = 4;
    localparam int SEQ_W       = 32;
    localparam int IDX_W       = 16;
    localparam int RETRY_W     = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int CFG_W       = 16;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_RETRANS_ENABLE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TYPE_MASK       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_REQUEST_RETRIES = 2'd2;

    localparam logic [RETRY_W-1:0] RETRIES_MIN = 3'd1;
    localparam logic [RETRY_W-1:0] RETRIES_MAX = 3'd6;

    typedef enum logic [1:0] {
        CMD_STATUS  = 2'd0,
        CMD_BURST   = 2'd1,
        CMD_SESSION = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [3:0]         pkt_type;
        logic [SEQ_W-1:0]   base_seq;
        logic [MISS_W-1:0]  missing;
        logic               seen;
    } cmd_t;

endpackage

`default_nettype wire

@@ hdl/sgng_front.sv @@
// front end: accepts headers, tracks sequence numbers per type, queues commands
`default_nettype none

module sgng_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         mode,
    input  wire logic [3:0]                   pkt_type,
    input  wire logic [sgng_pkg::SEQ_W-1:0]   seq_num,
    input  wire logic                         was_retransmitted,
    input  wire logic                         is_request_pkt,
    input  wire logic                         retrans_enable,
    input  wire logic [15:0]                  type_mask,
    input  wire logic                         q_full,
    output logic                              q_push,
    output sgng_pkg::cmd_t                    q_data
);

    logic [sgng_pkg::NUM_TYPES-1:0] type_seen_reg;
    logic [sgng_pkg::NUM_TYPES-1:0] type_seen_next;
    logic [sgng_pkg::SEQ_W-1:0]     prev_seq_reg [sgng_pkg::NUM_TYPES];
    logic [sgng_pkg::TYPE_W-1:0]    tidx;
    logic                           type_ok;
    logic                           enabled;
    logic                           seen;
    logic [sgng_pkg::SEQ_W-1:0]     prev_seq;
    logic [sgng_pkg::SEQ_W-1:0]     diff;
    logic                           fwd;
    logic                           gap;
    logic [sgng_pkg::MISS_W-1:0]    missing;
    logic                           accept;
    logic                           seq_wr;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign tidx     = sgng_pkg::TYPE_W'(pkt_type);
    assign type_ok  = {28'd0, pkt_type} < 32'(sgng_pkg::NUM_TYPES);
    assign enabled  = retrans_enable && ((type_mask == 16'd0) || type_mask[pkt_type]);
    assign seen     = was_retransmitted && enabled;
    assign prev_seq = prev_seq_reg[tidx];
    assign diff     = seq_num - prev_seq;
    assign fwd      = (diff != '0) && !diff[sgng_pkg::SEQ_W-1];
    assign gap      = fwd && (diff != sgng_pkg::SEQ_W'(1));
    assign missing  = (diff > sgng_pkg::SEQ_W'(sgng_pkg::MAX_MISSING + 1))
                      ? sgng_pkg::MISS_W'(sgng_pkg::MAX_MISSING)
                      : sgng_pkg::MISS_W'(diff - sgng_pkg::SEQ_W'(1));

    always_comb
    begin
        type_seen_next = type_seen_reg;
        seq_wr         = 1'b0;
        q_push         = accept;
        q_data.kind     = sgng_pkg::CMD_STATUS;
        q_data.pkt_type = 4'd0;
        q_data.base_seq = prev_seq;
        q_data.missing  = '0;
        q_data.seen     = 1'b0;
        priority if (mode)
        begin
            q_data.kind = sgng_pkg::CMD_SESSION;
            if (accept)
            begin
                type_seen_next = '0;
            end
        end
        else if (is_request_pkt)
        begin
            q_data.kind = sgng_pkg::CMD_STATUS;
        end
        else
        begin
            q_data.pkt_type = pkt_type;
            q_data.seen     = seen;
            if (retrans_enable && type_ok)
            begin
                if (!type_seen_reg[tidx])
                begin
                    if (accept)
                    begin
                        type_seen_next[tidx] = 1'b1;
                    end
                    seq_wr = accept;
                end
                else
                begin
                    if (gap && enabled)
                    begin
                        q_data.kind    = sgng_pkg::CMD_BURST;
                        q_data.missing = missing;
                    end
                    seq_wr = accept && fwd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_seen_reg <= '0;
        end
        else
        begin
            type_seen_reg <= type_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_wr)
        begin
            prev_seq_reg[tidx] <= seq_num;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sgng_queue.sv @@
// short command queue between front end and request generator
`default_nettype none

module sgng_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sgng_pkg::cmd_t  wr_data,
    output logic                 full,
    input  wire logic            pop,
    output sgng_pkg::cmd_t       rd_data,
    output logic                 empty
);

    sgng_pkg::cmd_t             mem [sgng_pkg::Q_DEPTH];
    logic [sgng_pkg::Q_AW-1:0]  wr_ptr_reg;
    logic [sgng_pkg::Q_AW-1:0]  rd_ptr_reg;
    logic [sgng_pkg::Q_AW:0]    count_reg;
    logic [sgng_pkg::Q_AW:0]    count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full    = count_reg == (sgng_pkg::Q_AW+1)'(sgng_pkg::Q_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sgng_back.sv @@
// back end: expands queued commands into request and status transactions
`default_nettype none

module sgng_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire sgng_pkg::cmd_t                 cmd,
    input  wire logic                           q_empty,
    output logic                                q_pop,
    input  wire logic [sgng_pkg::RETRY_W-1:0]   retries,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                is_nack,
    output logic [3:0]                          nack_type,
    output logic [sgng_pkg::SEQ_W-1:0]          nack_seq,
    output logic [sgng_pkg::IDX_W-1:0]          nack_index,
    output logic                                retrans_seen,
    output logic [sgng_pkg::MISS_W-1:0]         missing_added,
    output logic                                last
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    sgng_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [sgng_pkg::MISS_W-1:0]     i_reg, i_next;
    logic [sgng_pkg::RETRY_W-1:0]    r_reg, r_next;
    logic [sgng_pkg::IDX_W-1:0]      counter_reg, counter_next;
    logic                            valid_reg, valid_next;
    logic                            nack_reg, nack_next;
    logic [3:0]                      type_reg, type_next;
    logic [sgng_pkg::SEQ_W-1:0]      seq_reg, seq_next;
    logic [sgng_pkg::IDX_W-1:0]      index_reg, index_next;
    logic                            seen_reg, seen_next;
    logic [sgng_pkg::MISS_W-1:0]     added_reg, added_next;
    logic                            last_reg, last_next;
    logic                            can_emit;
    sgng_pkg::cmd_t                  cur;
    logic [sgng_pkg::MISS_W-1:0]     cur_i;
    logic [sgng_pkg::RETRY_W-1:0]    cur_r;
    logic                            req_last;
    logic                            r_wrap;

    assign can_emit = !valid_reg || out_ready;

    assign out_valid     = valid_reg;
    assign is_nack       = nack_reg;
    assign nack_type     = type_reg;
    assign nack_seq      = seq_reg;
    assign nack_index    = index_reg;
    assign retrans_seen  = seen_reg;
    assign missing_added = added_reg;
    assign last          = last_reg;

    // current request position: first one on pop, else the stored one
    assign cur      = (state_reg == ST_IDLE) ? cmd : cmd_reg;
    assign cur_i    = (state_reg == ST_IDLE) ? sgng_pkg::MISS_W'(1) : i_reg;
    assign cur_r    = (state_reg == ST_IDLE) ? '0 : r_reg;
    assign r_wrap   = cur_r == (retries - 1'b1);
    assign req_last = r_wrap && (cur_i == cur.missing);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        i_next       = i_reg;
        r_next       = r_reg;
        counter_next = counter_reg;
        valid_next   = valid_reg;
        nack_next    = nack_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        index_next   = index_reg;
        seen_next    = seen_reg;
        added_next   = added_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;

        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (can_emit && !q_empty)
                begin
                    q_pop      = 1'b1;
                    valid_next = 1'b1;
                    seen_next  = cmd.seen;
                    type_next  = cmd.pkt_type;
                    unique case (cmd.kind)
                        sgng_pkg::CMD_BURST:
                        begin
                            nack_next    = 1'b1;
                            seq_next     = cmd.base_seq + sgng_pkg::SEQ_W'(cur_i);
                            index_next   = counter_reg;
                            counter_next = counter_reg + 1'b1;
                            added_next   = cmd.missing;
                            last_next    = req_last;
                            cmd_next     = cmd;
                            i_next       = r_wrap ? cur_i + 1'b1 : cur_i;
                            r_next       = r_wrap ? '0 : cur_r + 1'b1;
                            if (!req_last)
                            begin
                                state_next = ST_BURST;
                            end
                        end
                        sgng_pkg::CMD_SESSION:
                        begin
                            nack_next    = 1'b0;
                            seq_next     = '0;
                            index_next   = '0;
                            added_next   = '0;
                            last_next    = 1'b1;
                            counter_next = '0;
                        end
                        default:
                        begin
                            nack_next  = 1'b0;
                            seq_next   = '0;
                            index_next = '0;
                            added_next = '0;
                            last_next  = 1'b1;
                        end
                    endcase
                end
            end
            ST_BURST:
            begin
                if (can_emit)
                begin
                    valid_next   = 1'b1;
                    nack_next    = 1'b1;
                    type_next    = cmd_reg.pkt_type;
                    seen_next    = cmd_reg.seen;
                    added_next   = cmd_reg.missing;
                    seq_next     = cmd_reg.base_seq + sgng_pkg::SEQ_W'(cur_i);
                    index_next   = counter_reg;
                    counter_next = counter_reg + 1'b1;
                    last_next    = req_last;
                    i_next       = r_wrap ? cur_i + 1'b1 : cur_i;
                    r_next       = r_wrap ? '0 : cur_r + 1'b1;
                    if (req_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            counter_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        i_reg     <= i_next;
        r_reg     <= r_next;
        nack_reg  <= nack_next;
        type_reg  <= type_next;
        seq_reg   <= seq_next;
        index_reg <= index_next;
        seen_reg  <= seen_next;
        added_reg <= added_next;
        last_reg  <= last_next;
    end

endmodule

`default_nettype wire

@@ hdl/sequence_gap_nack_generator.sv @@
// top level: sequence gap detector issuing retransmission requests
//
// channel   direction  transaction
// s_axis    in         packet header or new-session event
// m_axis    out        one request, or one status result per header
// wr_*      in         register write, no read-back
//
// the front end takes one header per cycle while the queue has room
// a header's command goes through the queue into the output register
// each header gives one result, or missing x request_retries requests
// (up to 60) at one per cycle from the back end while m_axis is ready
// a long burst fills the queue and then stalls s_axis; m_axis stalls hold
// the output register; asynchronous reset, no clearing pass
`default_nettype none

module sequence_gap_nack_generator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pkt_type[3:0], seq_num[35:4], was_retransmitted[36], zero fill
    input  wire logic [39:0]                      s_axis_tdata,
    // mode[0], is_request_pkt[1]
    input  wire logic [1:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // nack_type[3:0], nack_seq[35:4], nack_index[51:36], retrans_seen[52],
    // missing_added[56:53], zero fill
    output logic [63:0]                           m_axis_tdata,
    // is_nack
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    input  wire logic                             wr_en,
    input  wire logic [sgng_pkg::REG_IDX_W-1:0]   wr_index,
    input  wire logic [sgng_pkg::CFG_W-1:0]       wr_data
);

    logic                               retrans_enable_reg;
    logic [15:0]                        type_mask_reg;
    logic [sgng_pkg::RETRY_W-1:0]       retries_reg;
    logic [sgng_pkg::RETRY_W-1:0]       retries_wr;
    sgng_pkg::cmd_t                     push_cmd;
    sgng_pkg::cmd_t                     pop_cmd;
    logic                               q_push;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_empty;
    logic                               is_nack;
    logic [3:0]                         nack_type;
    logic [sgng_pkg::SEQ_W-1:0]         nack_seq;
    logic [sgng_pkg::IDX_W-1:0]         nack_index;
    logic                               retrans_seen;
    logic [sgng_pkg::MISS_W-1:0]        missing_added;

    always_comb
    begin
        retries_wr = wr_data[sgng_pkg::RETRY_W-1:0];
        if (retries_wr < sgng_pkg::RETRIES_MIN)
        begin
            retries_wr = sgng_pkg::RETRIES_MIN;
        end
        else if (retries_wr > sgng_pkg::RETRIES_MAX)
        begin
            retries_wr = sgng_pkg::RETRIES_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retrans_enable_reg <= 1'b0;
            type_mask_reg      <= '0;
            retries_reg        <= sgng_pkg::RETRIES_MIN;
        end
        else if (wr_en)
        begin
            if (wr_index == sgng_pkg::REG_RETRANS_ENABLE)
            begin
                retrans_enable_reg <= wr_data[0];
            end
            if (wr_index == sgng_pkg::REG_TYPE_MASK)
            begin
                type_mask_reg <= wr_data[15:0];
            end
            if (wr_index == sgng_pkg::REG_REQUEST_RETRIES)
            begin
                retries_reg <= retries_wr;
            end
        end
    end

    sgng_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .mode              (s_axis_tuser[0]),
        .pkt_type          (s_axis_tdata[3:0]),
        .seq_num           (s_axis_tdata[35:4]),
        .was_retransmitted (s_axis_tdata[36]),
        .is_request_pkt    (s_axis_tuser[1]),
        .retrans_enable    (retrans_enable_reg),
        .type_mask         (type_mask_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_data            (push_cmd)
    );

    sgng_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (pop_cmd),
        .empty   (q_empty)
    );

    sgng_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (pop_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .retries       (retries_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .is_nack       (is_nack),
        .nack_type     (nack_type),
        .nack_seq      (nack_seq),
        .nack_index    (nack_index),
        .retrans_seen  (retrans_seen),
        .missing_added (missing_added),
        .last          (m_axis_tlast)
    );

    assign m_axis_tuser = is_nack;
    assign m_axis_tdata = {7'd0, missing_added, retrans_seen, nack_index, nack_seq, nack_type};

endmodule

`default_nettype wire

@@ verif/sgng_checker.sv @@
// scoreboard for the sequence gap nack generator: predicts and compares every result transaction
`default_nettype none

module sgng_checker
    import sgng_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    // pkt_type[3:0], seq_num[35:4], was_retransmitted[36], zero fill
    input  wire logic [39:0]            s_axis_tdata,
    // mode[0], is_request_pkt[1]
    input  wire logic [1:0]             s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // nack_type[3:0], nack_seq[35:4], nack_index[51:36], retrans_seen[52],
    // missing_added[56:53], zero fill
    input  wire logic [63:0]            m_axis_tdata,
    // is_nack
    input  wire logic                   m_axis_tuser,
    input  wire logic                   m_axis_tlast,
    input  wire logic                   wr_en,
    input  wire logic [REG_IDX_W-1:0]   wr_index,
    input  wire logic [CFG_W-1:0]       wr_data,
    output int                          mismatch_count,
    output int                          backlog_depth
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic               is_nack;
        logic [3:0]         nack_type;
        logic [SEQ_W-1:0]   nack_seq;
        logic [IDX_W-1:0]   nack_index;
        logic               retrans_seen;
        logic [MISS_W-1:0]  missing_added;
        logic               last;
    } nack_result_t;

    logic                   type_seen [NUM_TYPES];
    logic [SEQ_W-1:0]       seq_by_type [NUM_TYPES];
    logic [IDX_W-1:0]       next_index;
    logic                   cfg_enable;
    logic [CFG_W-1:0]       cfg_mask;
    logic [RETRY_W-1:0]     cfg_retries;
    nack_result_t           nack_backlog [$];
    int                     errors;

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns mismatch %s: expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    task automatic predict_nacks(input logic [39:0] data, input logic [1:0] user);
        logic [3:0]         t;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   prev;
        logic [SEQ_W-1:0]   diff;
        logic               rtx;
        logic               enabled;
        logic               seen;
        int                 missing;
        int                 added;
        int                 produced;
        nack_result_t       res;
        t        = data[3:0];
        seq      = data[35:4];
        rtx      = data[36];
        missing  = 0;
        added    = 0;
        produced = 0;
        res      = '{default: '0};
        res.last = 1'b1;
        if (user[0])
        begin
            // new session
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                type_seen[i]   = 1'b0;
                seq_by_type[i] = '0;
            end
            next_index = '0;
            nack_backlog.push_back(res);
        end
        else if (user[1])
        begin
            nack_backlog.push_back(res);
        end
        else
        begin
            enabled = cfg_enable && (cfg_mask == '0 || cfg_mask[t]);
            seen    = rtx && enabled;
            if (cfg_enable && int'(t) < NUM_TYPES)
            begin
                if (!type_seen[t])
                begin
                    type_seen[t]   = 1'b1;
                    seq_by_type[t] = seq;
                end
                else
                begin
                    prev = seq_by_type[t];
                    diff = seq - prev;
                    // forward jump of two or more in signed wrapping terms
                    if (diff >= 32'd2 && diff <= 32'h7FFF_FFFF)
                    begin
                        missing = (diff - 32'd1 > 32'(MAX_MISSING)) ?
                                  MAX_MISSING : int'(diff - 32'd1);
                        if (enabled)
                        begin
                            added = missing;
                            for (int i = 1; i <= missing; i++)
                            begin
                                for (int r = 0; r < int'(cfg_retries); r++)
                                begin
                                    res.is_nack       = 1'b1;
                                    res.nack_type     = t;
                                    res.nack_seq      = prev + SEQ_W'(i);
                                    res.nack_index    = next_index;
                                    res.retrans_seen  = seen;
                                    res.missing_added = MISS_W'(added);
                                    res.last          = (i == missing) &&
                                                        (r == int'(cfg_retries) - 1);
                                    nack_backlog.push_back(res);
                                    next_index = next_index + 1'b1;
                                    produced++;
                                end
                            end
                        end
                    end
                    if (diff >= 32'd1 && diff <= 32'h7FFF_FFFF)
                        seq_by_type[t] = seq;
                end
            end
            if (produced == 0)
            begin
                res.nack_type     = t;
                res.retrans_seen  = seen;
                res.missing_added = MISS_W'(added);
                res.last          = 1'b1;
                nack_backlog.push_back(res);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        nack_result_t           want;
        logic [RETRY_W-1:0]     raw_retries;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                type_seen[i]   = 1'b0;
                seq_by_type[i] = '0;
            end
            next_index  = '0;
            cfg_enable  = 1'b0;
            cfg_mask    = '0;
            cfg_retries = RETRIES_MIN;
            errors      = 0;
            nack_backlog.delete();
            backlog_depth  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_RETRANS_ENABLE:  cfg_enable = wr_data[0];
                    REG_TYPE_MASK:       cfg_mask = wr_data;
                    REG_REQUEST_RETRIES:
                    begin
                        raw_retries = wr_data[RETRY_W-1:0];
                        if (raw_retries < RETRIES_MIN)
                            cfg_retries = RETRIES_MIN;
                        else if (raw_retries > RETRIES_MAX)
                            cfg_retries = RETRIES_MAX;
                        else
                            cfg_retries = raw_retries;
                    end
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_nacks(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (nack_backlog.size() == 0)
                begin
                    errors++;
                    $display("%0t ns unexpected transaction: expected none, actual tdata %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = nack_backlog.pop_front();
                    check_field("is_nack", 64'(want.is_nack), 64'(m_axis_tuser));
                    check_field("nack_type", 64'(want.nack_type), 64'(m_axis_tdata[3:0]));
                    check_field("nack_seq", 64'(want.nack_seq), 64'(m_axis_tdata[35:4]));
                    check_field("nack_index", 64'(want.nack_index), 64'(m_axis_tdata[51:36]));
                    check_field("retrans_seen", 64'(want.retrans_seen),
                                64'(m_axis_tdata[52]));
                    check_field("missing_added", 64'(want.missing_added),
                                64'(m_axis_tdata[56:53]));
                    check_field("zero fill", 64'd0, 64'(m_axis_tdata[63:57]));
                    check_field("tlast", 64'(want.last), 64'(m_axis_tlast));
                end
            end
            backlog_depth  <= nack_backlog.size();
            mismatch_count <= errors;
        end
    end

endmodule

`default_nettype wire

@@ verif/tb_sequence_gap_nack_generator.sv @@
// testbench top for the sequence gap nack generator: stimulus, flow control and verdict
`default_nettype none

module tb_sequence_gap_nack_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import sgng_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 46;

    localparam logic MODE_HEADER  = 1'b0;
    localparam logic MODE_SESSION = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [39:0]            s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [63:0]            m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   wr_en = 1'b0;
    logic [REG_IDX_W-1:0]   wr_index = '0;
    logic [CFG_W-1:0]       wr_data = '0;
    int                     mismatch_count;
    int                     backlog_depth;
    int                     cycles = 0;
    int                     ready_left = 0;
    logic                   sender_gaps_on = 1'b1;
    logic [SEQ_W-1:0]       stim_last [NUM_TYPES];

    sequence_gap_nack_generator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data)
    );

    sgng_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .mismatch_count (mismatch_count),
        .backlog_depth  (backlog_depth)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL sequence_gap_nack_generator");
            $finish;
        end
    end

    // receiver back-pressure: short toggles, long open stretches, a few long stalls
    always @(posedge clk)
    begin
        int pick;
        if (ready_left == 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(1, 6);
            end
            else if (pick < 80)
            begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(1, 3);
            end
            else if (pick < 93)
            begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(20, 80);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(10, 40);
            end
        end
        else
        begin
            ready_left = ready_left - 1;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // upper bits carry junk that the block must ignore
    task automatic program_regs(input logic en, input logic [CFG_W-1:0] mask,
                                input logic [RETRY_W-1:0] raw_retries);
        write_reg(REG_RETRANS_ENABLE, {15'($urandom), en});
        write_reg(REG_TYPE_MASK, mask);
        write_reg(REG_REQUEST_RETRIES, {13'($urandom), raw_retries});
        write_reg(REG_SPARE, 16'($urandom));
        wr_en <= 1'b0;
    endtask

    task automatic send_item(input logic mode, input logic req, input logic [3:0] t,
                             input logic [SEQ_W-1:0] seq, input logic rtx);
        int pick;
        int gap;
        gap = 0;
        if (sender_gaps_on)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                gap = 0;
            else if (pick < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 30);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rtx, seq, t};
        s_axis_tuser  <= {req, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_header(input logic [3:0] t, input logic [SEQ_W-1:0] seq,
                               input logic rtx);
        send_item(MODE_HEADER, 1'b0, t, seq, rtx);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (backlog_depth != 0);
    endtask

    task automatic random_item();
        int pick;
        logic [3:0] t;
        logic [SEQ_W-1:0] seq;
        pick = $urandom_range(0, 99);
        t = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        if (pick < 3)
        begin
            send_item(MODE_SESSION, 1'($urandom), t, $urandom, 1'($urandom));
        end
        else if (pick < 8)
        begin
            send_item(MODE_HEADER, 1'b1, t, $urandom, 1'($urandom));
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                seq = stim_last[t] + 32'd1;
            else if (pick < 60)
                seq = stim_last[t] + $urandom_range(2, 4);
            else if (pick < 72)
                seq = stim_last[t] + $urandom_range(5, 20);
            else if (pick < 82)
                seq = stim_last[t] - $urandom_range(0, 5);
            else if (pick < 90)
                seq = $urandom;
            else if (pick < 95)
                seq = stim_last[t] + 32'h7FFF_FFFF - $urandom_range(0, 2);
            else
                seq = stim_last[t] + 32'h8000_0000 + $urandom_range(0, 2);
            if (pick < 72 || (pick >= 82 && pick < 95))
                stim_last[t] = seq;
            send_header(t, seq, ($urandom_range(0, 3) == 0));
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0]   mask;
        logic [RETRY_W-1:0] raw_retries;
        logic               en;
        for (int i = 0; i < NUM_TYPES; i++)
            stim_last[i] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tracking disabled after reset
        send_header(4'd3, 32'd100, 1'b1);
        send_header(4'd3, 32'd105, 1'b0);
        wait_idle();

        // retries written as zero, all types allowed
        program_regs(1'b1, 16'h0000, 3'd0);
        send_header(4'd0, 32'hFFFF_FFFE, 1'b0);
        send_header(4'd0, 32'd1, 1'b0);
        send_header(4'd0, 32'd1, 1'b0);
        send_header(4'd0, 32'd0, 1'b0);
        send_header(4'd0, 32'd2, 1'b0);
        send_header(4'd0, 32'h8000_0001, 1'b0);
        send_header(4'd0, 32'h0000_0001, 1'b0);
        send_header(4'd15, 32'hFFFF_FFFF, 1'b1);
        send_header(4'd15, 32'd11, 1'b1);
        send_item(MODE_HEADER, 1'b1, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_SESSION, 1'b1, 4'd9, 32'hA5A5_5A5A, 1'b1);
        send_header(4'd15, 32'd5, 1'b0);
        wait_idle();

        // retries written as seven, only types 0 and 15 allowed
        program_regs(1'b1, 16'h8001, 3'd7);
        send_header(4'd15, 32'd17, 1'b1);
        send_header(4'd7, 32'd0, 1'b0);
        send_header(4'd7, 32'd5, 1'b1);
        send_header(4'd7, 32'd6, 1'b0);
        send_header(4'd0, 32'd4, 1'b1);
        wait_idle();

        program_regs(1'b0, 16'hFFFF, 3'd3);
        send_header(4'd0, 32'd50, 1'b1);
        send_header(4'd0, 32'd80, 1'b0);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            en = ($urandom_range(0, 7) != 0);
            raw_retries = 3'($urandom);
            case ($urandom_range(0, 4))
                0, 1:    mask = 16'h0000;
                2:       mask = 16'hFFFF;
                3:       mask = 16'($urandom);
                default: mask = 16'h0001 << $urandom_range(0, 15);
            endcase
            if (phase == 0)
            begin
                en = 1'b1;
                mask = 16'h0000;
                raw_retries = 3'd6;
            end
            else if (phase == 1)
            begin
                en = 1'b1;
                mask = 16'hFFFF;
                raw_retries = 3'd1;
            end
            sender_gaps_on = (phase % 3 != 2);
            program_regs(en, mask, raw_retries);
            repeat (ITEMS_PER_PHASE) random_item();
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS sequence_gap_nack_generator");
        else
            $display("FAIL sequence_gap_nack_generator");
        $finish;
    end

endmodule

`default_nettype wire

@@ sequence_gap_nack_generator.f @@
hdl/sgng_pkg.sv
hdl/sgng_front.sv
hdl/sgng_queue.sv
hdl/sgng_back.sv
hdl/sequence_gap_nack_generator.sv
verif/sgng_checker.sv
verif/tb_sequence_gap_nack_generator.sv
